// File: design/unique_set_min_max_tracker_macros.svh
// Assertion helpers used by the checker module.
`ifndef UNIQUE_SET_MIN_MAX_TRACKER_MACROS_SVH
`define UNIQUE_SET_MIN_MAX_TRACKER_MACROS_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define USMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define USMM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: design/usmm_pkg.sv
package usmm_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int VALUE_BITS_DEFAULT = 16;

   localparam int REQ_TYPE_BITS = 2;
   localparam int ITEM_BITS     = 16;
   localparam int INDEX_BITS    = 4;
   localparam int STATUS_BITS   = 3;
   localparam int POS_BITS      = 4;
   localparam int COUNT_BITS    = 5;

   typedef logic [REQ_TYPE_BITS-1:0] req_kind_type;
   typedef logic [STATUS_BITS-1:0]   status_type;

   // request kinds
   localparam req_kind_type REQ_INSERT = 2'd0;
   localparam req_kind_type REQ_FIND   = 2'd1;
   localparam req_kind_type REQ_READ   = 2'd2;

   // result status codes
   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_DUPLICATE = 3'd1;
   localparam status_type ST_NOT_FOUND = 3'd2;
   localparam status_type ST_OUT_OF_BOUNDS = 3'd3;
   localparam status_type ST_FULL      = 3'd4;

endpackage

// File: design/usmm_req_if.sv
interface usmm_req_if;
   import usmm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [REQ_TYPE_BITS-1:0] req_type;
   logic [ITEM_BITS-1:0]     item_value;
   logic [INDEX_BITS-1:0]    entry_index;

   modport source (output valid, req_type, item_value, entry_index, input ready);
   modport sink   (input valid, req_type, item_value, entry_index, output ready);
endinterface

// File: design/usmm_rsp_if.sv
interface usmm_rsp_if;
   import usmm_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [POS_BITS-1:0]    position;
   logic [ITEM_BITS-1:0]   read_value;
   logic [ITEM_BITS-1:0]   min_value;
   logic [ITEM_BITS-1:0]   max_value;
   logic [COUNT_BITS-1:0]  entry_count;
   logic [COUNT_BITS-1:0]  capacity;
   logic                   is_empty;

   modport source (output valid, status, position, read_value, min_value, max_value,
                   entry_count, capacity, is_empty, input ready);
   modport sink   (input valid, status, position, read_value, min_value, max_value,
                   entry_count, capacity, is_empty, output ready);
endinterface

// File: design/unique_set_min_max_tracker.sv
// Flow: insert and find scan the store from slot zero until a hit or the last entry
//    (one to entry_count entries, at least one); a read waits for its RAM word; an
//    out-of-range read or an unused kind goes straight to the result stage.
// Throughput: one item at a time; the scan reads one entry per cycle from the store RAM.
// Reset: synchronous, active high; clears count, capacity, min, max and the result
//    valid; the store RAM is not cleared, only entries below the count are used.
module unique_set_min_max_tracker #(
   parameter int DEPTH      = usmm_pkg::DEPTH_DEFAULT,
   parameter int VALUE_BITS = usmm_pkg::VALUE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   usmm_req_if.sink   req_chan,
   usmm_rsp_if.source rsp_chan
);
   import usmm_pkg::*;

   localparam int AddrW = $clog2(DEPTH);
   localparam int CntW  = $clog2(DEPTH + 1);
   localparam int CapW  = AddrW + 1;

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_RDWAIT = 2'd2;
   localparam logic [1:0] S_OUT    = 2'd3;

   // control state
   logic [1:0]            state_ff, state_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic [CapW-1:0]       cap_ff, cap_in;
   logic [VALUE_BITS-1:0] min_ff, min_in;
   logic [VALUE_BITS-1:0] max_ff, max_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // item under work
   req_kind_type          kind_ff, kind_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [AddrW-1:0]      ptr_ff, ptr_in;
   status_type            res_status_ff, res_status_in;
   logic [AddrW-1:0]      res_pos_ff, res_pos_in;
   logic [VALUE_BITS-1:0] res_read_ff, res_read_in;

   // result register
   status_type              rsp_status_ff, rsp_status_in;
   logic [POS_BITS-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [ITEM_BITS-1:0]    rsp_read_ff, rsp_read_in;
   logic [ITEM_BITS-1:0]    rsp_min_ff, rsp_min_in;
   logic [ITEM_BITS-1:0]    rsp_max_ff, rsp_max_in;
   logic [COUNT_BITS-1:0]   rsp_count_ff, rsp_count_in;
   logic [COUNT_BITS-1:0]   rsp_cap_ff, rsp_cap_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   // store RAM
   logic                  ram_wr_en;
   logic [AddrW-1:0]      ram_wr_addr;
   logic [VALUE_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [AddrW-1:0]      ram_rd_addr;
   logic [VALUE_BITS-1:0] ram_rd_data;

   logic                  scan_hit;
   logic                  scan_last;
   logic [CntW-1:0]       count_inc;
   logic                  store_empty;

   usmm_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The RAM word in front of us belongs to ptr_ff; only slots below the count count as hits.
   assign scan_hit    = (ram_rd_data == value_ff) && (CntW'(ptr_ff) < count_ff);
   assign scan_last   = (CntW'(ptr_ff) + CntW'(1)) >= count_ff;
   assign count_inc   = count_ff + CntW'(1);
   assign store_empty = (count_ff == '0);

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      ptr_in        = ptr_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_read_in   = res_read_ff;

      // drop the result once the sink takes it
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_cap_in    = rsp_cap_ff;
      rsp_empty_in  = rsp_empty_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = AddrW'(count_ff);
      ram_wr_data = value_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ptr_ff + AddrW'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               kind_in       = req_chan.req_type;
               value_in      = VALUE_BITS'(req_chan.item_value);
               ptr_in        = '0;
               res_status_in = ST_OK;
               res_pos_in    = '0;
               res_read_in   = '0;
               unique case (req_chan.req_type)
                  REQ_INSERT, REQ_FIND: begin
                     // start the scan at slot zero
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = S_SCAN;
                  end
                  REQ_READ: begin
                     if (32'(req_chan.entry_index) < 32'(count_ff)) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AddrW'(req_chan.entry_index);
                        state_in    = S_RDWAIT;
                     end else begin
                        res_status_in = ST_OUT_OF_BOUNDS;
                        state_in      = S_OUT;
                     end
                  end
                  default: begin
                     // unused kind: plain ok, no state change
                     state_in = S_OUT;
                  end
               endcase
            end
         end

         S_SCAN: begin
            priority if (scan_hit) begin
               if (kind_ff == REQ_INSERT) begin
                  res_status_in = ST_DUPLICATE;
               end else begin
                  res_pos_in = ptr_ff;
               end
               state_in = S_OUT;
            end else if (scan_last) begin
               if (kind_ff == REQ_FIND) begin
                  res_status_in = ST_NOT_FOUND;
               end else if (count_ff == CntW'(DEPTH)) begin
                  res_status_in = ST_FULL;
               end else begin
                  // append at the tail and fold into min, max and capacity
                  ram_wr_en = 1'b1;
                  count_in  = count_inc;
                  if (store_empty) begin
                     min_in = value_ff;
                     max_in = value_ff;
                  end else begin
                     if (value_ff < min_ff) begin
                        min_in = value_ff;
                     end
                     if (value_ff > max_ff) begin
                        max_in = value_ff;
                     end
                  end
                  if (CapW'(count_inc) > cap_ff) begin
                     cap_in = store_empty ? CapW'(1) : (cap_ff << 1);
                  end
               end
               state_in = S_OUT;
            end else begin
               // advance to the next slot; its word arrives next cycle
               ptr_in    = ptr_ff + AddrW'(1);
               ram_rd_en = 1'b1;
            end
         end

         S_RDWAIT: begin
            res_read_in = ram_rd_data;
            state_in    = S_OUT;
         end

         S_OUT: begin
            // hold until the result register is free or being emptied
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = POS_BITS'(res_pos_ff);
               rsp_read_in   = ITEM_BITS'(res_read_ff);
               rsp_min_in    = store_empty ? '0 : ITEM_BITS'(min_ff);
               rsp_max_in    = store_empty ? '0 : ITEM_BITS'(max_ff);
               rsp_count_in  = COUNT_BITS'(count_ff);
               rsp_cap_in    = COUNT_BITS'(cap_ff);
               rsp_empty_in  = store_empty;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_read_ff   <= res_read_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_cap_ff    <= rsp_cap_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.position    = rsp_pos_ff;
   assign rsp_chan.read_value  = rsp_read_ff;
   assign rsp_chan.min_value   = rsp_min_ff;
   assign rsp_chan.max_value   = rsp_max_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.capacity    = rsp_cap_ff;
   assign rsp_chan.is_empty    = rsp_empty_ff;
endmodule

// File: design/usmm_ram.sv
module usmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: design/usmm_checker.sv
`include "unique_set_min_max_tracker_macros.svh"

module usmm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [usmm_pkg::STATUS_BITS-1:0] rsp_status,
   input logic [usmm_pkg::ITEM_BITS-1:0]   rsp_min_value,
   input logic [usmm_pkg::ITEM_BITS-1:0]   rsp_max_value,
   input logic [usmm_pkg::COUNT_BITS-1:0]  rsp_entry_count,
   input logic [usmm_pkg::COUNT_BITS-1:0]  rsp_capacity,
   input logic                             rsp_is_empty
);
   // a stalled result stays put
   `USMM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count), "stalled result changed")
   // one item at a time: a request transfer closes the input for the next cycle
   `USMM_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")
   // empty flag agrees with count, min, max and capacity
   `USMM_ASSERT_SAME(a_empty_view, clock, reset, rsp_valid && rsp_is_empty, (rsp_entry_count == '0) && (rsp_min_value == '0) && (rsp_max_value == '0) && (rsp_capacity == '0), "empty result carries data")
   // a non-empty set orders min at or below max
   `USMM_ASSERT_SAME(a_min_le_max, clock, reset, rsp_valid && !rsp_is_empty, (rsp_min_value <= rsp_max_value) && (rsp_entry_count != '0), "min above max")
endmodule

bind unique_set_min_max_tracker usmm_checker u_usmm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_min_value   (rsp_chan.min_value),
   .rsp_max_value   (rsp_chan.max_value),
   .rsp_entry_count (rsp_chan.entry_count),
   .rsp_capacity    (rsp_chan.capacity),
   .rsp_is_empty    (rsp_chan.is_empty)
);

// File: verif/tb_unique_set_min_max_tracker.sv
module tb_unique_set_min_max_tracker;
   import usmm_pkg::*;

   // Table geometry as built by the default parameters of the block.
   localparam int TABLE_DEPTH  = DEPTH_DEFAULT;
   localparam int CLOCK_PERIOD = 12;
   // Settle time after the drain, above the worst single request with a full-table scan.
   localparam int SETTLE_CYCLES = 3 * (3 + DEPTH_DEFAULT);
   // Long receiver hold-off, well past a single scan.
   localparam int LONG_HOLD_CYCLES = 90;

   // Request kind 3 is not decoded by the block; it still answers with status ok.
   localparam req_kind_type REQ_UNUSED = 2'd3;

   // One result as the block reports it.
   typedef struct packed {
      status_type             status;
      logic [POS_BITS-1:0]    position;
      logic [ITEM_BITS-1:0]   read_value;
      logic [ITEM_BITS-1:0]   min_value;
      logic [ITEM_BITS-1:0]   max_value;
      logic [COUNT_BITS-1:0]  entry_count;
      logic [COUNT_BITS-1:0]  capacity;
      logic                   is_empty;
   } table_outcome_type;

   localparam int OUTCOME_FIELDS = 8;

   logic clock;
   logic reset;

   usmm_req_if req_bus ();
   usmm_rsp_if rsp_bus ();

   unique_set_min_max_tracker u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // ---------------------------------------------------------------------
   // Shadow copy of the value table, updated at each request transfer.
   // ---------------------------------------------------------------------
   logic [ITEM_BITS-1:0]  stored_values [TABLE_DEPTH];
   int                    stored_total;
   logic [ITEM_BITS-1:0]  low_mark;
   logic [ITEM_BITS-1:0]  high_mark;
   logic [COUNT_BITS-1:0] doubled_capacity;

   // Results owed by the block, oldest first.
   table_outcome_type pending_outcomes [$];

   int error_count;
   int requests_sent;
   int results_checked;
   int status_tally [5];
   int kind_tally [4];

   // Idle and hold-off controls shared by the driver, the receiver and the tests.
   bit sender_idle_on;
   bit receiver_idle_on;
   bit long_hold_pending;
   int long_holds_done;

   // Return the slot that holds the value, or -1 when it is not stored.
   function automatic int find_slot(input logic [ITEM_BITS-1:0] value);
      for (int i = 0; i < stored_total; i++) begin
         if (stored_values[i] == value) return i;
      end
      return -1;
   endfunction

   // Apply one request to the shadow table and return the result it must produce.
   function automatic table_outcome_type apply_table_request(input req_kind_type kind,
                                                             input logic [ITEM_BITS-1:0] value,
                                                             input logic [INDEX_BITS-1:0] index);
      table_outcome_type outcome;
      int                hit;
      outcome = '0;
      hit     = find_slot(value);
      case (kind)
         REQ_INSERT: begin
            if (hit >= 0) begin
               outcome.status = ST_DUPLICATE;
            end else if (stored_total >= TABLE_DEPTH) begin
               outcome.status = ST_FULL;
            end else begin
               stored_values[stored_total] = value;
               if (stored_total == 0) begin
                  low_mark  = value;
                  high_mark = value;
               end else begin
                  if (value < low_mark) low_mark = value;
                  if (value > high_mark) high_mark = value;
               end
               stored_total++;
               // round the count up to a power of two
               doubled_capacity = COUNT_BITS'(1);
               while (doubled_capacity < stored_total) doubled_capacity = doubled_capacity << 1;
            end
         end
         REQ_FIND: begin
            if (hit >= 0) outcome.position = hit[POS_BITS-1:0];
            else outcome.status = ST_NOT_FOUND;
         end
         REQ_READ: begin
            if (index < stored_total) outcome.read_value = stored_values[index];
            else outcome.status = ST_OUT_OF_BOUNDS;
         end
         default: ;
      endcase
      outcome.is_empty    = (stored_total == 0);
      outcome.min_value   = outcome.is_empty ? '0 : low_mark;
      outcome.max_value   = outcome.is_empty ? '0 : high_mark;
      outcome.entry_count = stored_total[COUNT_BITS-1:0];
      outcome.capacity    = doubled_capacity;
      status_tally[outcome.status]++;
      kind_tally[kind]++;
      return outcome;
   endfunction

   function automatic string field_label(input int sel);
      case (sel)
         0: return "status";
         1: return "position";
         2: return "read_value";
         3: return "min_value";
         4: return "max_value";
         5: return "entry_count";
         6: return "capacity";
         default: return "is_empty";
      endcase
   endfunction

   function automatic logic [ITEM_BITS-1:0] field_of(input table_outcome_type outcome,
                                                      input int sel);
      case (sel)
         0: return ITEM_BITS'(outcome.status);
         1: return ITEM_BITS'(outcome.position);
         2: return outcome.read_value;
         3: return outcome.min_value;
         4: return outcome.max_value;
         5: return ITEM_BITS'(outcome.entry_count);
         6: return ITEM_BITS'(outcome.capacity);
         default: return ITEM_BITS'(outcome.is_empty);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Clock and time limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Far above the slowest legal run: every request scanning a full table,
   // waiting out the longest gaps on both sides, plus the long hold-off.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result receiver: drop ready in random bursts, or for one long hold-off
   // when a test asks for it; the hold-off is counted here, in cycles.
   // ---------------------------------------------------------------------
   initial begin
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
            if (hold_left == 0 && long_hold_pending) begin
               long_hold_pending = 1'b0;
               long_holds_done++;
            end
         end else if (long_hold_pending) begin
            rsp_bus.ready <= 1'b0;
            hold_left = LONG_HOLD_CYCLES - 1;
         end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left = $urandom_range(0, 12);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: compare each result transfer with the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      table_outcome_type observed;
      table_outcome_type predicted;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         observed.status      = rsp_bus.status;
         observed.position    = rsp_bus.position;
         observed.read_value  = rsp_bus.read_value;
         observed.min_value   = rsp_bus.min_value;
         observed.max_value   = rsp_bus.max_value;
         observed.entry_count = rsp_bus.entry_count;
         observed.capacity    = rsp_bus.capacity;
         observed.is_empty    = rsp_bus.is_empty;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, observed);
            error_count++;
         end else begin
            predicted = pending_outcomes.pop_front();
            results_checked++;
            for (int f = 0; f < OUTCOME_FIELDS; f++) begin
               if (field_of(observed, f) !== field_of(predicted, f)) begin
                  $display("%0t: %s mismatch, expected %0h, got %0h", $time,
                           field_label(f), field_of(predicted, f), field_of(observed, f));
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request driver: offer one request, hold it until the transfer, then
   // record what the block owes for it. Valid stays high into the next call
   // unless a gap is chosen.
   // ---------------------------------------------------------------------
   task automatic send_request(input req_kind_type kind,
                               input logic [ITEM_BITS-1:0] value,
                               input logic [INDEX_BITS-1:0] index);
      int gap;
      gap = 0;
      if (sender_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= kind;
      req_bus.item_value  <= value;
      req_bus.entry_index <= index;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_outcomes.push_back(apply_table_request(kind, value, index));
      requests_sent++;
   endtask

   // Pick a value already in the table when there is one, so that finds and
   // repeat inserts hit; otherwise any value.
   function automatic logic [ITEM_BITS-1:0] known_value();
      if (stored_total == 0) return ITEM_BITS'($urandom);
      return stored_values[$urandom_range(0, stored_total - 1)];
   endfunction

   // Mostly well-formed traffic: finds and reads aimed at stored entries,
   // repeat inserts, a trickle of new values so the table fills slowly, and
   // some misses, stray reads and unused kinds.
   task automatic run_request_mix(input int n_items, input int fresh_pct);
      int roll;
      for (int n = 0; n < n_items; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < fresh_pct)
            send_request(REQ_INSERT, ITEM_BITS'($urandom), INDEX_BITS'($urandom));
         else if (roll < fresh_pct + 10)
            send_request(REQ_INSERT, known_value(), INDEX_BITS'($urandom));
         else if (roll < fresh_pct + 40)
            send_request(REQ_FIND, known_value(), INDEX_BITS'($urandom));
         else if (roll < fresh_pct + 50)
            send_request(REQ_FIND, ITEM_BITS'($urandom), INDEX_BITS'($urandom));
         else if (roll < fresh_pct + 82)
            send_request(REQ_READ, ITEM_BITS'($urandom),
                         INDEX_BITS'($urandom_range(0, stored_total > 0 ? stored_total - 1 : 0)));
         else if (roll < fresh_pct + 92)
            send_request(REQ_READ, ITEM_BITS'($urandom), INDEX_BITS'($urandom_range(0, 15)));
         else
            send_request(REQ_UNUSED, ITEM_BITS'($urandom), INDEX_BITS'($urandom));
      end
   endtask

   // Withdraw the last request, then hold the sender until the block owes nothing.
   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Empty table: every lookup misses, every read is out of range, min and
   // max report zero with the empty flag set.
   task automatic test_empty_table();
      send_request(REQ_FIND, 16'h0000, 4'd0);
      send_request(REQ_FIND, 16'hFFFF, 4'd15);
      send_request(REQ_READ, 16'h0000, 4'd0);
      send_request(REQ_READ, 16'hFFFF, 4'd15);
      send_request(REQ_UNUSED, 16'h0000, 4'd0);
   endtask

   // Extreme values: first insert sets both marks, then the top and bottom
   // of the range move max and min; a repeat insert is a duplicate; finds
   // and reads at the edges of the stored count.
   task automatic test_value_extremes();
      send_request(REQ_INSERT, 16'h8000, 4'd0);
      send_request(REQ_INSERT, 16'hFFFF, 4'd0);
      send_request(REQ_INSERT, 16'h0000, 4'd15);
      send_request(REQ_INSERT, 16'hFFFF, 4'd0);
      send_request(REQ_FIND, 16'h0000, 4'd0);
      send_request(REQ_FIND, 16'hFFFF, 4'd0);
      send_request(REQ_FIND, 16'h1234, 4'd0);
      send_request(REQ_READ, 16'h0000, 4'd0);
      send_request(REQ_READ, 16'h0000, 4'd2);
      send_request(REQ_READ, 16'h0000, 4'd3);
      send_request(REQ_READ, 16'hFFFF, 4'd15);
      send_request(REQ_UNUSED, 16'hFFFF, 4'd15);
   endtask

   // Bulk random traffic with idling on both sides; a trickle of fresh inserts
   // fills the table slowly, one entry at a time.
   task automatic test_random_traffic();
      run_request_mix(400, 4);
   endtask

   // Hold the receiver off long enough that the block holds a result and
   // stops taking requests while the driver keeps offering them.
   task automatic test_receiver_hold_off();
      sender_idle_on    = 1'b0;
      long_hold_pending = 1'b1;
      run_request_mix(12, 4);
      sender_idle_on    = 1'b1;
   endtask

   // Pause the sender until every owed result has come back, then resume.
   task automatic test_sender_drain_pause();
      wait_for_drain();
      run_request_mix(10, 4);
   endtask

   // Closing stretch with no idling on either side: each request is offered as soon as the last is taken.
   task automatic test_back_to_back();
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      run_request_mix(60, 4);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int settle;
      // drive every input to a known value from time zero
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = REQ_INSERT;
      req_bus.item_value  = '0;
      req_bus.entry_index = '0;
      stored_total        = 0;
      low_mark            = '0;
      high_mark           = '0;
      doubled_capacity    = '0;
      error_count         = 0;
      requests_sent       = 0;
      results_checked     = 0;
      long_holds_done     = 0;
      long_hold_pending   = 1'b0;
      sender_idle_on      = 1'b1;
      receiver_idle_on    = 1'b1;
      foreach (status_tally[s]) status_tally[s] = 0;
      foreach (kind_tally[k]) kind_tally[k] = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_value_extremes();
      test_random_traffic();
      test_receiver_hold_off();
      test_sender_drain_pause();
      test_back_to_back();

      @(negedge clock);
      req_bus.valid <= 1'b0;

      // wait for every owed result, then watch a while longer for strays
      wait_for_drain();
      settle = SETTLE_CYCLES;
      while (settle > 0) begin
         @(posedge clock);
         settle--;
      end

      if (pending_outcomes.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_outcomes.size());
         error_count++;
      end

      $write("Sent %0d requests (insert %0d, find %0d, read %0d, unused %0d), ",
             requests_sent, kind_tally[REQ_INSERT], kind_tally[REQ_FIND],
             kind_tally[REQ_READ], kind_tally[REQ_UNUSED]);
      $display("checked %0d results.", results_checked);
      $write("Status seen: ok %0d, duplicate %0d, not found %0d, out of range %0d, full %0d; ",
             status_tally[ST_OK], status_tally[ST_DUPLICATE], status_tally[ST_NOT_FOUND],
             status_tally[ST_OUT_OF_BOUNDS], status_tally[ST_FULL]);
      $display("final count %0d, long hold-offs %0d.", stored_total, long_holds_done);

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/usmm_pkg.sv
design/usmm_req_if.sv
design/usmm_rsp_if.sv
design/usmm_ram.sv
design/unique_set_min_max_tracker.sv
design/usmm_checker.sv
verif/tb_unique_set_min_max_tracker.sv
